/* rtl/nrle_pkg.sv */
package nrle_pkg;

  // parser phases
  localparam logic [2:0] PH_TOKEN    = 3'd0;
  localparam logic [2:0] PH_BYTE_HI  = 3'd1;
  localparam logic [2:0] PH_COUNT_HI = 3'd2;
  localparam logic [2:0] PH_BYTE_LO  = 3'd3;
  localparam logic [2:0] PH_COUNT_LO = 3'd4;
  localparam logic [2:0] PH_KEY      = 3'd5;

  // token codes
  localparam logic [3:0] TOK_LAST_LIT = 4'hB;
  localparam logic [3:0] TOK_RAW_SEQ  = 4'hC;
  localparam logic [3:0] TOK_KEY_RUN  = 4'hD;
  localparam logic [3:0] TOK_BYTE_RUN = 4'hE;
  localparam logic [3:0] TOK_RAW_ONE  = 4'hF;

  // configuration register indexes
  localparam logic CFG_PALETTE_LOW  = 1'b0;
  localparam logic CFG_PALETTE_HIGH = 1'b1;

  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned QUEUE_DEPTH   = 4;

  typedef struct packed {
    logic [2:0] phase;
    logic [3:0] code;
    logic [7:0] count;
    logic [3:0] high;
    logic [8:0] raw_left;
  } parse_st_t;

  // one result: either a raw byte or a palette key still to be translated
  typedef struct packed {
    logic       is_key;
    logic [7:0] val;
    logic [8:0] len;
  } result_t;

  // one queue entry: the results of one input beat
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic not_full;
    logic not_empty;
  } queue_stat_t;

endpackage

/* rtl/nrle_front.sv */
module nrle_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_start_of_image,
  input  logic [7:0]           in_packed_byte,
  input  nrle_pkg::queue_stat_t qstat,
  output logic                 push,
  output nrle_pkg::entry_t     push_entry
);
  import nrle_pkg::*;

  typedef struct packed {
    parse_st_t st;
    logic      hit;
    result_t   res;
  } feed_t;

  function automatic logic [8:0] run_len(input logic [7:0] cnt);
    run_len = (cnt == 8'd0) ? 9'd256 : {1'b0, cnt};
  endfunction

  function automatic feed_t feed(input parse_st_t s, input logic [3:0] n);
    feed_t f;
    f.st  = s;
    f.hit = 1'b0;
    f.res = '0;
    unique case (s.phase)
      PH_BYTE_HI: begin
        f.st.high  = n;
        f.st.phase = PH_BYTE_LO;
      end
      PH_COUNT_HI: begin
        f.st.high  = n;
        f.st.phase = PH_COUNT_LO;
      end
      PH_BYTE_LO: begin
        f.hit        = 1'b1;
        f.res.is_key = 1'b0;
        f.res.val    = {s.high, n};
        f.res.len    = 9'd1;
        f.st.phase   = PH_TOKEN;
        if (s.code == TOK_BYTE_RUN) begin
          f.res.len = run_len(s.count);
        end else if (s.code == TOK_RAW_SEQ) begin
          f.st.raw_left = s.raw_left - 9'd1;
          f.st.phase    = (f.st.raw_left == 9'd0) ? PH_TOKEN : PH_BYTE_HI;
        end
      end
      PH_COUNT_LO: begin
        f.st.count = {s.high, n};
        if (s.code == TOK_KEY_RUN) begin
          f.st.phase = PH_KEY;
        end else begin
          if (s.code == TOK_RAW_SEQ) f.st.raw_left = run_len({s.high, n});
          f.st.phase = PH_BYTE_HI;
        end
      end
      PH_KEY: begin
        f.hit        = 1'b1;
        f.res.is_key = 1'b1;
        f.res.val    = {4'd0, n};
        f.res.len    = run_len(s.count);
        f.st.phase   = PH_TOKEN;
      end
      default: begin
        // token phase, also the unused codes
        f.st.code = n;
        if (n <= TOK_LAST_LIT) begin
          f.hit        = 1'b1;
          f.res.is_key = 1'b1;
          f.res.val    = {4'd0, n};
          f.res.len    = 9'd1;
          f.st.phase   = PH_TOKEN;
        end else begin
          f.st.phase = (n == TOK_RAW_ONE) ? PH_BYTE_HI : PH_COUNT_HI;
        end
      end
    endcase
    return f;
  endfunction

  parse_st_t st_r, st_nxt;
  parse_st_t st_start;
  feed_t     f_hi, f_lo;
  logic      accept;

  assign in_ready = qstat.not_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    st_start = in_start_of_image ? parse_st_t'('0) : st_r;
    f_hi     = feed(st_start, in_packed_byte[7:4]);
    f_lo     = feed(f_hi.st, in_packed_byte[3:0]);
    push            = accept && (f_hi.hit || f_lo.hit);
    push_entry.two  = f_hi.hit && f_lo.hit;
    push_entry.r0   = f_hi.hit ? f_hi.res : f_lo.res;
    push_entry.r1   = f_lo.res;
    st_nxt          = accept ? f_lo.st : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

/* rtl/nrle_fifo.sv */
module nrle_fifo #(
  parameter int unsigned Depth = nrle_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  nrle_pkg::entry_t      push_entry,
  input  logic                  pop,
  output nrle_pkg::entry_t      head,
  output nrle_pkg::queue_stat_t qstat
);
  import nrle_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Depth);

  entry_t            mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;

  assign head            = mem_r[rd_ptr_r];
  assign qstat.not_full  = (cnt_r != CntMax);
  assign qstat.not_empty = (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PtrMax) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PtrMax) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

/* rtl/nrle_back.sv */
module nrle_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [nrle_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  nrle_pkg::entry_t                 head,
  input  logic                             head_valid,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_out_byte,
  output logic [8:0]                       out_repeat_len,
  output logic                             out_last
);
  import nrle_pkg::*;

  logic [CFG_DATA_W-1:0] pal_low_r, pal_high_r;
  logic                  valid_r, valid_nxt;
  logic                  sel_r, sel_nxt;
  logic [7:0]            byte_r;
  logic [8:0]            len_r;
  logic                  last_r;
  logic                  load;
  result_t               cur;
  logic                  cur_last;
  logic [CFG_DATA_W-1:0] word;
  logic [7:0]            cur_byte;

  assign out_valid      = valid_r;
  assign out_out_byte   = byte_r;
  assign out_repeat_len = len_r;
  assign out_last       = last_r;

  always_comb begin
    load      = head_valid && (!valid_r || out_ready);
    cur       = sel_r ? head.r1 : head.r0;
    cur_last  = sel_r || !head.two;
    pop       = load && cur_last;
    word      = cur.val[3] ? pal_high_r : pal_low_r;
    cur_byte  = cur.is_key ? word[{cur.val[2:0], 3'b000} +: 8] : cur.val;
    valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);
    sel_nxt   = load ? !cur_last : sel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      sel_r      <= 1'b0;
      pal_low_r  <= '0;
      pal_high_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PALETTE_LOW:  pal_low_r  <= cfg_wdata;
          CFG_PALETTE_HIGH: pal_high_r <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      len_r  <= cur.len;
      last_r <= cur_last;
    end
  end

endmodule

/* rtl/nibble_rle_image_decoder.sv */
// path: an accepted beat is written to the result queue, then loaded into the output register
// throughput: one input beat per cycle while out_ready is high and each beat gives at
//   most one result; a two-result beat holds the single output register for both,
//   and the result queue of QueueDepth entries absorbs the difference
// reset: synchronous active low rst_n clears the parser, queue pointers, output valid
//   and both palette registers; no clearing pass is needed
module nibble_rle_image_decoder #(
  parameter int unsigned QueueDepth = nrle_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_start_of_image,
  input  logic [7:0]                      in_packed_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_out_byte,
  output logic [8:0]                      out_repeat_len,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [nrle_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import nrle_pkg::*;

  // front to queue: one entry per beat that yields any result
  logic        q_push;
  entry_t      q_push_entry;
  // queue to back
  entry_t      q_head;
  queue_stat_t q_stat;
  logic        q_pop;

  // front: two nibble parser steps per beat, palette keys left untranslated
  nrle_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_of_image (in_start_of_image),
    .in_packed_byte    (in_packed_byte),
    .qstat             (q_stat),
    .push              (q_push),
    .push_entry        (q_push_entry)
  );

  // short queue lets the parser run ahead of a stalled output
  nrle_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .qstat      (q_stat)
  );

  // back: splits an entry into results, translates keys, drives the output register
  nrle_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .head           (q_head),
    .head_valid     (q_stat.not_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_repeat_len (out_repeat_len),
    .out_last       (out_last)
  );

  // the back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.not_empty)
    else $error("queue popped while empty");

  // an empty queue always has room for the next beat
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.not_empty |-> in_ready)
    else $error("input stalled with empty queue");

  // every shown result has a run length of 1 to 256
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_repeat_len != 9'd0) && (out_repeat_len <= 9'd256))
    else $error("run length out of range");

  // a beat that gives results is queued only when accepted
  a_push_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_valid && in_ready))
    else $error("queue written without an accepted beat");

endmodule
